>>> hdl/swv_pkg.sv
// Shared types and constants for the per-symbol windowed VWAP core.
package swv_pkg;

  // Default sizing.
  localparam int unsigned NUM_SYMBOLS_DEF  = 64;
  localparam int unsigned WINDOW_DEPTH_DEF = 256;

  // Configuration register reset values.
  localparam logic [15:0] RATIO_RESET  = 16'd6554;
  localparam logic [30:0] WINDOW_RESET = 31'd3600;

  // Configuration register indexes.
  localparam logic CFG_RATIO  = 1'b0;
  localparam logic CFG_WINDOW = 1'b1;

  // One trade tick.
  typedef struct packed {
    logic [5:0]  symbol_index;
    logic [31:0] tick_price;
    logic [30:0] tick_time;
    logic [23:0] tick_volume;
  } swv_in_t;

  // One answer per tick.
  typedef struct packed {
    logic [5:0]  symbol_echo;
    logic        accepted;
    logic [31:0] vwap;
    logic        vwap_valid;
    logic        ring_overflow;
    logic [8:0]  window_count;
  } swv_out_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOAD,
    ST_CHECK,
    ST_JUDGE,
    ST_PUSH,
    ST_PUSH_ADD,
    ST_EV_RD,
    ST_EV_MUL,
    ST_EV_SUB,
    ST_FINISH,
    ST_DIV,
    ST_DELIVER
  } swv_state_t;

endpackage

>>> hdl/swv_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module swv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/swv_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module swv_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] rem_sh;
  logic [32:0] rem_sub;

  // One shift-and-subtract step per cycle.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    rem_sh   = {rem_r, quo_r[63]};
    rem_sub  = rem_sh - {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = rem_sub[31:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[31:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      step_nxt = step_r + 6'd1;
      if (step_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> hdl/per_symbol_windowed_vwap_core.sv
// Top level of the per-symbol sliding-window VWAP core.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    swv_in_t tick
//   out_      output     out_valid / out_ready  swv_out_t answer
//   cfg_      input      cfg_we                 cfg_index, cfg_data
//
// One tick is in work at a time. A tick that enters the window takes longer than
// a rejected tick, with an eviction pass added for each entry evicted by age and
// one more when the ring is full. The divider sets most of the time; a zero
// volume sum skips it.
// After reset a clearing pass over all NUM_SYMBOLS entries zeroes the per-symbol
// state memory; in_ready stays low during it.
// A finished answer waits in the output register while the next tick is taken.
module per_symbol_windowed_vwap_core #(
  parameter int unsigned NUM_SYMBOLS  = swv_pkg::NUM_SYMBOLS_DEF,
  parameter int unsigned WINDOW_DEPTH = swv_pkg::WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swv_pkg::swv_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output swv_pkg::swv_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [30:0]       cfg_data
);

  localparam int unsigned SYM_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned DEP_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned RDEPTH = NUM_SYMBOLS * WINDOW_DEPTH;
  localparam int unsigned RA_W   = $clog2(RDEPTH);
  localparam int unsigned ST_W   = DEP_W + CNT_W + 128;
  localparam int unsigned RG_W   = 87;

  swv_pkg::swv_state_t state_r, state_nxt;
  logic [SYM_W-1:0] clr_r, clr_nxt;
  swv_pkg::swv_in_t req_r, req_nxt;
  logic [5:0]       sym_r, sym_nxt;
  logic [DEP_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0]      wsum_r, wsum_nxt;
  logic [31:0]      vsum_r, vsum_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [55:0]      prod_r, prod_nxt;
  logic [31:0]      diff_r, diff_nxt;
  logic [23:0]      evvol_r, evvol_nxt;
  logic             acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;
  logic             full_r, full_nxt;
  logic [31:0]      q_r, q_nxt;
  swv_pkg::swv_out_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [15:0]      ratio_r;
  logic [30:0]      winlen_r;

  // Memory ports.
  logic             st_we;
  logic [SYM_W-1:0] st_waddr, st_raddr;
  logic [ST_W-1:0]  st_wdata, st_rdata;
  logic             rg_we;
  logic [RA_W-1:0]  rg_waddr, rg_raddr;
  logic [RG_W-1:0]  rg_wdata, rg_rdata;

  // Divider.
  logic             div_start;
  logic             div_done;
  logic [63:0]      div_quo;

  // Ring slot arithmetic.
  logic [SYM_W-1:0] sym_idx;
  logic [RA_W-1:0]  ring_base;
  logic [DEP_W:0]   tail_sum;
  logic [DEP_W-1:0] tail_slot;
  logic [DEP_W-1:0] head_inc;
  logic [31:0]      ev_price;
  logic [30:0]      ev_time;
  logic [23:0]      ev_vol;
  logic             expired;
  logic             reject;

  assign sym_idx   = SYM_W'(sym_r);
  assign ring_base = RA_W'(RA_W'(sym_idx) * RA_W'(WINDOW_DEPTH));
  assign tail_sum  = (DEP_W + 1)'(head_r) + (DEP_W + 1)'(cnt_r);
  assign tail_slot = (tail_sum >= (DEP_W + 1)'(WINDOW_DEPTH))
                     ? DEP_W'(tail_sum - (DEP_W + 1)'(WINDOW_DEPTH)) : DEP_W'(tail_sum);
  assign head_inc  = (32'(head_r) == WINDOW_DEPTH - 1) ? '0 : head_r + DEP_W'(1);
  assign {ev_price, ev_time, ev_vol} = rg_rdata;
  assign expired   = (req_r.tick_time > ev_time) && ((req_r.tick_time - ev_time) > winlen_r);
  assign reject    = (last_r != 32'd0) && ({diff_r, 16'd0} > prod_r[47:0]);

  // Sequencer next state and datapath.
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    req_nxt       = req_r;
    sym_nxt       = sym_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    wsum_nxt      = wsum_r;
    vsum_nxt      = vsum_r;
    last_nxt      = last_r;
    prod_nxt      = prod_r;
    diff_nxt      = diff_r;
    evvol_nxt     = evvol_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    full_nxt      = full_r;
    q_nxt         = q_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    st_we         = 1'b0;
    st_waddr      = sym_idx;
    st_wdata      = {head_r, cnt_r, wsum_r, vsum_r, last_r};
    st_raddr      = sym_idx;
    rg_we         = 1'b0;
    rg_waddr      = ring_base + RA_W'(tail_slot);
    rg_wdata      = {req_r.tick_price, req_r.tick_time, req_r.tick_volume};
    rg_raddr      = ring_base + RA_W'(head_r);
    div_start     = 1'b0;

    // The taker drains the output register independently of the sequencer.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      swv_pkg::ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        st_wdata = '0;
        clr_nxt  = clr_r + SYM_W'(1);
        if (32'(clr_r) == NUM_SYMBOLS - 1) begin
          state_nxt = swv_pkg::ST_IDLE;
        end
      end
      swv_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt   = in_data;
          sym_nxt   = in_data.symbol_index;
          acc_nxt   = 1'b1;
          ovf_nxt   = 1'b0;
          full_nxt  = 1'b0;
          state_nxt = swv_pkg::ST_REDUCE;
        end
      end
      swv_pkg::ST_REDUCE: begin
        // Symbol modulo NUM_SYMBOLS by repeated subtraction.
        if (32'(sym_r) >= NUM_SYMBOLS) begin
          sym_nxt = sym_r - 6'(NUM_SYMBOLS);
        end else begin
          state_nxt = swv_pkg::ST_LOAD;
        end
      end
      swv_pkg::ST_LOAD: begin
        {head_nxt, cnt_nxt, wsum_nxt, vsum_nxt, last_nxt} = st_rdata;
        state_nxt = swv_pkg::ST_CHECK;
      end
      swv_pkg::ST_CHECK: begin
        diff_nxt  = (req_r.tick_price >= last_r) ? req_r.tick_price - last_r
                                                 : last_r - req_r.tick_price;
        prod_nxt  = 56'(ratio_r * last_r);
        state_nxt = swv_pkg::ST_JUDGE;
      end
      swv_pkg::ST_JUDGE: begin
        if (reject) begin
          acc_nxt   = 1'b0;
          state_nxt = swv_pkg::ST_FINISH;
        end else if (32'(cnt_r) >= WINDOW_DEPTH) begin
          ovf_nxt   = 1'b1;
          full_nxt  = 1'b1;
          state_nxt = swv_pkg::ST_EV_RD;
        end else begin
          state_nxt = swv_pkg::ST_PUSH;
        end
      end
      swv_pkg::ST_PUSH: begin
        rg_we     = 1'b1;
        prod_nxt  = 56'(req_r.tick_price * req_r.tick_volume);
        cnt_nxt   = cnt_r + CNT_W'(1);
        vsum_nxt  = vsum_r + 32'(req_r.tick_volume);
        last_nxt  = req_r.tick_price;
        state_nxt = swv_pkg::ST_PUSH_ADD;
      end
      swv_pkg::ST_PUSH_ADD: begin
        wsum_nxt  = wsum_r + 64'(prod_r);
        full_nxt  = 1'b0;
        state_nxt = swv_pkg::ST_EV_RD;
      end
      swv_pkg::ST_EV_RD: begin
        // Read address is the head slot; data returns next cycle.
        state_nxt = swv_pkg::ST_EV_MUL;
      end
      swv_pkg::ST_EV_MUL: begin
        prod_nxt  = 56'(ev_price * ev_vol);
        evvol_nxt = ev_vol;
        if (full_r || expired) begin
          state_nxt = swv_pkg::ST_EV_SUB;
        end else begin
          state_nxt = swv_pkg::ST_FINISH;
        end
      end
      swv_pkg::ST_EV_SUB: begin
        wsum_nxt = wsum_r - 64'(prod_r);
        vsum_nxt = vsum_r - 32'(evvol_r);
        head_nxt = head_inc;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (full_r) begin
          state_nxt = swv_pkg::ST_PUSH;
        end else if (cnt_r > CNT_W'(1)) begin
          state_nxt = swv_pkg::ST_EV_RD;
        end else begin
          state_nxt = swv_pkg::ST_FINISH;
        end
      end
      swv_pkg::ST_FINISH: begin
        st_we = 1'b1;
        if (vsum_r != 32'd0) begin
          div_start = 1'b1;
          state_nxt = swv_pkg::ST_DIV;
        end else begin
          q_nxt     = '0;
          state_nxt = swv_pkg::ST_DELIVER;
        end
      end
      swv_pkg::ST_DIV: begin
        if (div_done) begin
          q_nxt     = (div_quo[63:32] != 32'd0) ? '1 : div_quo[31:0];
          state_nxt = swv_pkg::ST_DELIVER;
        end
      end
      swv_pkg::ST_DELIVER: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.symbol_echo   = req_r.symbol_index;
          out_nxt.accepted      = acc_r;
          out_nxt.vwap          = q_r;
          out_nxt.vwap_valid    = (vsum_r != 32'd0);
          out_nxt.ring_overflow = ovf_r;
          out_nxt.window_count  = 9'(cnt_r);
          out_valid_nxt         = 1'b1;
          state_nxt             = swv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swv_pkg::ST_IDLE;
    endcase
  end

  // State register and control flops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swv_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers for the tick in flight.
  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    sym_r   <= sym_nxt;
    head_r  <= head_nxt;
    cnt_r   <= cnt_nxt;
    wsum_r  <= wsum_nxt;
    vsum_r  <= vsum_nxt;
    last_r  <= last_nxt;
    prod_r  <= prod_nxt;
    diff_r  <= diff_nxt;
    evvol_r <= evvol_nxt;
    acc_r   <= acc_nxt;
    ovf_r   <= ovf_nxt;
    full_r  <= full_nxt;
    q_r     <= q_nxt;
    out_r   <= out_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= swv_pkg::RATIO_RESET;
      winlen_r <= swv_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swv_pkg::CFG_RATIO:  ratio_r  <= cfg_data[15:0];
        swv_pkg::CFG_WINDOW: winlen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-symbol head, count, sums and last price.
  swv_ram #(.WIDTH(ST_W), .DEPTH(NUM_SYMBOLS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Tick rings, all symbols side by side.
  swv_ram #(.WIDTH(RG_W), .DEPTH(RDEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (rg_we),
    .waddr (rg_waddr),
    .wdata (rg_wdata),
    .raddr (rg_raddr),
    .rdata (rg_rdata)
  );

  swv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (wsum_r),
    .divisor  (vsum_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // Only one tick is in work: no second transaction right after one is taken.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second input transaction accepted while busy");

  // A push never lands in a full ring.
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    rg_we |-> (32'(cnt_r) < WINDOW_DEPTH))
    else $error("ring push with full ring");

  // The divider is never started on a zero volume sum.
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (vsum_r != 32'd0))
    else $error("divider started with zero divisor");

  // An eviction step only happens with a nonempty ring.
  a_evict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == swv_pkg::ST_EV_SUB) |-> (cnt_r != '0))
    else $error("eviction from empty ring");
`endif

endmodule

>>> verif/tb_per_symbol_windowed_vwap_core.sv
// Self-checking testbench for the per-symbol sliding-window VWAP core.
`timescale 1ns / 100ps

module tb_per_symbol_windowed_vwap_core;

  localparam int NSYM  = 64;
  localparam int DEPTH = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  swv_pkg::swv_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  swv_pkg::swv_out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = swv_pkg::CFG_RATIO;
  logic [30:0] cfg_data = '0;
  logic in_took = 1'b0;

  per_symbol_windowed_vwap_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow state of the tick windows.
  logic [31:0] sh_price [NSYM*DEPTH];
  logic [30:0] sh_time  [NSYM*DEPTH];
  logic [23:0] sh_vol   [NSYM*DEPTH];
  int unsigned sh_head  [NSYM];
  int unsigned sh_count [NSYM];
  logic [63:0] sh_wsum  [NSYM];
  logic [31:0] sh_vsum  [NSYM];
  logic [31:0] sh_last  [NSYM];
  logic [15:0] sh_ratio;
  logic [30:0] sh_window;

  swv_pkg::swv_in_t  tick_queue[$];
  swv_pkg::swv_out_t answer_queue[$];
  int errors = 0;
  bit quiet_idle = 0;      // no random gaps while set
  bit hold_receiver = 0;   // ask the receiver for a long hold-off
  int watchdog = 0;
  logic [30:0] sym_clock [NSYM];

  function automatic void drop_oldest_tick(input int s);
    int slot;
    slot = s*DEPTH + sh_head[s];
    sh_wsum[s] -= {32'd0, sh_price[slot]} * {40'd0, sh_vol[slot]};
    sh_vsum[s] -= {8'd0, sh_vol[slot]};
    sh_head[s] = (sh_head[s] + 1) % DEPTH;
    sh_count[s]--;
  endfunction

  // Predict the answer to one tick and advance the shadow state.
  function automatic swv_pkg::swv_out_t predict_vwap(input swv_pkg::swv_in_t t);
    swv_pkg::swv_out_t r;
    int s, slot;
    logic [63:0] diff, q;
    logic acc, ovf;
    s = t.symbol_index % NSYM;
    acc = 1'b1;
    ovf = 1'b0;
    if (sh_last[s] != 0) begin
      diff = (t.tick_price >= sh_last[s]) ? 64'(t.tick_price - sh_last[s])
                                          : 64'(sh_last[s] - t.tick_price);
      if ((diff << 16) > 64'(sh_ratio) * 64'(sh_last[s])) acc = 1'b0;
    end
    if (acc) begin
      if (sh_count[s] >= DEPTH) begin
        drop_oldest_tick(s);
        ovf = 1'b1;
      end
      slot = s*DEPTH + (sh_head[s] + sh_count[s]) % DEPTH;
      sh_price[slot] = t.tick_price;
      sh_time[slot] = t.tick_time;
      sh_vol[slot] = t.tick_volume;
      sh_count[s]++;
      sh_wsum[s] += {32'd0, t.tick_price} * {40'd0, t.tick_volume};
      sh_vsum[s] += {8'd0, t.tick_volume};
      sh_last[s] = t.tick_price;
      while (sh_count[s] > 0) begin
        slot = s*DEPTH + sh_head[s];
        if (t.tick_time > sh_time[slot] && t.tick_time - sh_time[slot] > sh_window)
          drop_oldest_tick(s);
        else
          break;
      end
    end
    q = 0;
    if (sh_vsum[s] != 0) begin
      q = sh_wsum[s] / {32'd0, sh_vsum[s]};
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    end
    r.symbol_echo = t.symbol_index;
    r.accepted = acc;
    r.vwap = q[31:0];
    r.vwap_valid = (sh_vsum[s] != 0);
    r.ring_overflow = ovf;
    r.window_count = 9'(sh_count[s]);
    return r;
  endfunction

  // Remember whether the input transaction was taken at the last rising edge.
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
  end

  // Driver: offers queued ticks, with random gaps.
  always @(negedge clk) begin
    if (in_took) begin
      if (tick_queue.size() > 0 && (quiet_idle || $urandom_range(99) >= 32)) begin
        in_data <= tick_queue[0];
        tick_queue.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && rst_n && tick_queue.size() > 0 &&
                 (quiet_idle || $urandom_range(99) >= 32)) begin
      in_data <= tick_queue[0];
      tick_queue.delete(0);
      in_valid <= 1'b1;
    end
  end

  // Receiver readiness, with random stalls and one long hold-off.
  int hold_cycles = 0;
  always @(negedge clk) begin
    if (hold_receiver && hold_cycles == 0) hold_cycles = 3000;
    if (hold_cycles > 0) begin
      hold_cycles--;
      if (hold_cycles == 0) hold_receiver = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_idle || ($urandom_range(99) >= 32);
    end
  end

  // Monitor: predicts on each accepted tick and checks each answer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) answer_queue = {answer_queue, predict_vwap(in_data)};
      if (out_valid && out_ready) begin
        if (answer_queue.size() == 0) begin
          $display("%0t: unexpected answer %p", $time, out_data);
          errors++;
        end else begin
          swv_pkg::swv_out_t e;
          e = answer_queue[0];
          answer_queue.delete(0);
          if (e !== out_data) begin
            $display("%0t: answer mismatch expected %p actual %p", $time, e, out_data);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        watchdog = 0;
      else
        watchdog++;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic swv_pkg::swv_in_t make_tick(input int s, input logic [31:0] p,
                                                 input logic [30:0] t,
                                                 input logic [23:0] v);
    swv_pkg::swv_in_t k;
    k.symbol_index = 6'(s);
    k.tick_price = p;
    k.tick_time = t;
    k.tick_volume = v;
    return k;
  endfunction

  task automatic add_tick(input swv_pkg::swv_in_t k);
    tick_queue = {tick_queue, k};
  endtask

  task automatic wait_drained();
    while (tick_queue.size() > 0 || in_valid || answer_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == swv_pkg::CFG_RATIO) sh_ratio = val[15:0];
    else sh_window = val;
  endtask

  // Random phase: mostly plausible ticks around a shared base price, with per-symbol times, some noise.
  task automatic random_phase(input int n, input int nsym);
    int s;
    logic [31:0] p;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(nsym - 1);
      sym_clock[s] += 31'($urandom_range(400));
      if ($urandom_range(9) == 0) p = $urandom();
      else p = 32'd1000000 + $urandom_range(150000);
      if ($urandom_range(19) == 0)
        add_tick(make_tick($urandom_range(63), $urandom(),
                           31'($urandom()), 24'($urandom())));
      else
        add_tick(make_tick(s, p, sym_clock[s], 24'($urandom_range(5000))));
    end
  endtask

  initial begin
    for (int i = 0; i < NSYM; i++) begin
      sh_head[i] = 0; sh_count[i] = 0; sh_wsum[i] = 0;
      sh_vsum[i] = 0; sh_last[i] = 0; sym_clock[i] = 0;
    end
    for (int i = 0; i < NSYM*DEPTH; i++) begin
      sh_price[i] = 0; sh_time[i] = 0; sh_vol[i] = 0;
    end
    sh_ratio = swv_pkg::RATIO_RESET;
    sh_window = swv_pkg::WINDOW_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero price, volume extremes, jumps at the limit, echo extremes.
    add_tick(make_tick(0, 32'd0, 31'd0, 24'd0));
    add_tick(make_tick(0, 32'd100000, 31'd1, 24'hFFFFFF));
    add_tick(make_tick(0, 32'd110000, 31'd2, 24'd1));
    add_tick(make_tick(0, 32'd121001, 31'd3, 24'd1));
    add_tick(make_tick(0, 32'd0, 31'd4, 24'd5));
    add_tick(make_tick(63, 32'hFFFFFFFF, 31'h7FFFFFFF, 24'hFFFFFF));
    add_tick(make_tick(63, 32'hFFFFFFFF, 31'h7FFFFFFF, 24'hFFFFFF));
    add_tick(make_tick(63, 32'hFFFFFFFF, 31'd5, 24'd3));
    add_tick(make_tick(5, 32'd5000, 31'd100, 24'd7));
    add_tick(make_tick(5, 32'd5000, 31'd50, 24'd7));
    add_tick(make_tick(5, 32'd5001, 31'd4000, 24'd9));
    quiet_idle = 1;
    wait_drained();
    quiet_idle = 0;

    // Full ring: 260 ticks on one symbol at a fixed time, ratio at maximum.
    write_reg(swv_pkg::CFG_RATIO, 31'd65535);
    write_reg(swv_pkg::CFG_WINDOW, 31'h7FFFFFFF);
    for (int i = 0; i < 260; i++)
      add_tick(make_tick(9, 32'd20000 + i, 31'd10, 24'($urandom())));
    wait_drained();

    // Ratio zero: any change is rejected; window of one unit.
    write_reg(swv_pkg::CFG_RATIO, 31'd0);
    write_reg(swv_pkg::CFG_WINDOW, 31'd1);
    random_phase(80, 8);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    write_reg(swv_pkg::CFG_RATIO, 31'd6554);
    write_reg(swv_pkg::CFG_WINDOW, 31'd3600);
    hold_receiver = 1;
    random_phase(60, 16);
    wait_drained();

    // Main random phases across several settings.
    write_reg(swv_pkg::CFG_WINDOW, 31'd500);
    random_phase(150, 64);
    wait_drained();
    write_reg(swv_pkg::CFG_RATIO, 31'd40000);
    write_reg(swv_pkg::CFG_WINDOW, 31'd2000);
    quiet_idle = 1;
    random_phase(80, 4);
    wait_drained();
    quiet_idle = 0;
    write_reg(swv_pkg::CFG_RATIO, 31'd1000);
    random_phase(120, 32);
    wait_drained();

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
hdl/swv_pkg.sv
hdl/swv_ram.sv
hdl/swv_div.sv
hdl/per_symbol_windowed_vwap_core.sv
verif/tb_per_symbol_windowed_vwap_core.sv
